>>> sv/rotate_inverse_map_address_unit_defines.svh
// Assertion macros used by the checker file of the rotation address unit.
// Depends on nothing; include by bare file name.
`ifndef ROTATE_INVERSE_MAP_ADDRESS_UNIT_DEFINES_SVH
`define ROTATE_INVERSE_MAP_ADDRESS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RIMAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RIMAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/rimau_pkg.sv
// Package of the rotation address unit: sizes, register indexes and the configuration type.
// Depends on nothing.
package rimau_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = 13;
    localparam int COORD_W  = 12;
    localparam int ANGLE_W  = 16;
    localparam int CADDR_W  = 3;
    localparam int INDEX_W  = 24;
    localparam int CTR_W    = 14;
    localparam int PROD_W   = 30;
    localparam int SUM_W    = 31;
    localparam int FRAC_W   = 14;
    localparam int ROT_W    = SUM_W - FRAC_W;
    localparam int SRC_W    = ROT_W + 1;
    localparam int N_STAGES = 7;

    localparam logic [CADDR_W-1:0] REG_COS   = 3'd0;
    localparam logic [CADDR_W-1:0] REG_SIN   = 3'd1;
    localparam logic [CADDR_W-1:0] REG_SRC_W = 3'd2;
    localparam logic [CADDR_W-1:0] REG_SRC_H = 3'd3;
    localparam logic [CADDR_W-1:0] REG_DST_W = 3'd4;
    localparam logic [CADDR_W-1:0] REG_DST_H = 3'd5;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] cos_v;
        logic signed [ANGLE_W-1:0] sin_v;
        logic [DIM_W-1:0]          src_w;
        logic [DIM_W-1:0]          src_h;
        logic [DIM_W-1:0]          dst_w;
        logic [DIM_W-1:0]          dst_h;
    } t_cfg;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        if (v > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

endpackage

>>> sv/rimau_center.sv
// First pipeline stage: centers the destination coordinate on the destination frame.
// Depends on rimau_pkg.
module rimau_center (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  rimau_pkg::t_cfg                   i_cfg,
    input  logic [rimau_pkg::COORD_W-1:0]     i_dst_col,
    input  logic [rimau_pkg::COORD_W-1:0]     i_dst_row,
    output logic signed [rimau_pkg::CTR_W-1:0] o_xc,
    output logic signed [rimau_pkg::CTR_W-1:0] o_yc
);
    import rimau_pkg::*;

    logic signed [CTR_W-1:0] r_xc;
    logic signed [CTR_W-1:0] r_yc;
    logic signed [CTR_W-1:0] n_xc;
    logic signed [CTR_W-1:0] n_yc;

    always_comb begin
        n_xc = $signed({2'b00, i_dst_col}) - $signed({2'b00, i_cfg.dst_w[DIM_W-1:1]});
        n_yc = $signed({2'b00, i_dst_row}) - $signed({2'b00, i_cfg.dst_h[DIM_W-1:1]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xc <= n_xc;
            r_yc <= n_yc;
        end
    end

    assign o_xc = r_xc;
    assign o_yc = r_yc;

endmodule

>>> sv/rimau_rotate.sv
// Stages two to four: the four angle products, their sums, and the Q1.14 scaling
// with truncation toward zero. Depends on rimau_pkg.
module rimau_rotate (
    input  logic                               i_clk,
    input  logic [2:0]                         i_en,
    input  rimau_pkg::t_cfg                    i_cfg,
    input  logic signed [rimau_pkg::CTR_W-1:0] i_xc,
    input  logic signed [rimau_pkg::CTR_W-1:0] i_yc,
    output logic signed [rimau_pkg::ROT_W-1:0] o_xs,
    output logic signed [rimau_pkg::ROT_W-1:0] o_ys
);
    import rimau_pkg::*;

    logic signed [PROD_W-1:0] r_xc_cos;
    logic signed [PROD_W-1:0] r_yc_sin;
    logic signed [PROD_W-1:0] r_yc_cos;
    logic signed [PROD_W-1:0] r_xc_sin;
    logic signed [SUM_W-1:0]  r_sum_x;
    logic signed [SUM_W-1:0]  r_sum_y;
    logic signed [ROT_W-1:0]  r_xs;
    logic signed [ROT_W-1:0]  r_ys;
    logic signed [SUM_W-1:0]  n_adj_x;
    logic signed [SUM_W-1:0]  n_adj_y;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << FRAC_W) - 1);

    always_comb begin
        n_adj_x = r_sum_x + (r_sum_x[SUM_W-1] ? ROUND_BIAS : '0);
        n_adj_y = r_sum_y + (r_sum_y[SUM_W-1] ? ROUND_BIAS : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_xc_cos <= PROD_W'(i_xc) * PROD_W'($signed(i_cfg.cos_v));
            r_yc_sin <= PROD_W'(i_yc) * PROD_W'($signed(i_cfg.sin_v));
            r_yc_cos <= PROD_W'(i_yc) * PROD_W'($signed(i_cfg.cos_v));
            r_xc_sin <= PROD_W'(i_xc) * PROD_W'($signed(i_cfg.sin_v));
        end
        if (i_en[1]) begin
            r_sum_x <= SUM_W'(r_xc_cos) + SUM_W'(r_yc_sin);
            r_sum_y <= SUM_W'(r_yc_cos) - SUM_W'(r_xc_sin);
        end
        if (i_en[2]) begin
            r_xs <= n_adj_x[SUM_W-1:FRAC_W];
            r_ys <= n_adj_y[SUM_W-1:FRAC_W];
        end
    end

    assign o_xs = r_xs;
    assign o_ys = r_ys;

endmodule

>>> sv/rimau_locate.sv
// Stages five to seven: source position, frame test, and the linear source index.
// Depends on rimau_pkg.
module rimau_locate (
    input  logic                               i_clk,
    input  logic [2:0]                         i_en,
    input  rimau_pkg::t_cfg                    i_cfg,
    input  logic signed [rimau_pkg::ROT_W-1:0] i_xs,
    input  logic signed [rimau_pkg::ROT_W-1:0] i_ys,
    output logic [rimau_pkg::INDEX_W-1:0]      o_src_index,
    output logic                               o_in_image
);
    import rimau_pkg::*;

    logic signed [SRC_W-1:0]  r_sx;
    logic signed [SRC_W-1:0]  r_sy;
    logic                     r_inside;
    logic [2*DIM_W-1:0]       r_prod;
    logic [DIM_W-1:0]         r_sx_lo;
    logic [INDEX_W-1:0]       r_index;
    logic                     r_in_image;
    logic                     n_inside;
    logic [2*DIM_W-1:0]       n_sum;

    always_comb begin
        n_inside = !r_sx[SRC_W-1] && (r_sx[SRC_W-2:0] < (SRC_W-1)'(i_cfg.src_w)) &&
                   !r_sy[SRC_W-1] && (r_sy[SRC_W-2:0] < (SRC_W-1)'(i_cfg.src_h));
        n_sum    = r_prod + (2*DIM_W)'(r_sx_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sx <= SRC_W'(i_xs) + $signed({(SRC_W-DIM_W+1)'(0), i_cfg.src_w[DIM_W-1:1]});
            r_sy <= SRC_W'(i_ys) + $signed({(SRC_W-DIM_W+1)'(0), i_cfg.src_h[DIM_W-1:1]});
        end
        if (i_en[1]) begin
            r_inside <= n_inside;
            r_prod   <= (2*DIM_W)'(r_sy[DIM_W-1:0]) * (2*DIM_W)'(i_cfg.src_w);
            r_sx_lo  <= r_sx[DIM_W-1:0];
        end
        if (i_en[2]) begin
            r_index    <= r_inside ? n_sum[INDEX_W-1:0] : '0;
            r_in_image <= r_inside;
        end
    end

    assign o_src_index = r_index;
    assign o_in_image  = r_in_image;

endmodule

>>> sv/rotate_inverse_map_address_unit.sv
// Inverse-mapping address unit for nearest-neighbor image rotation. Each transaction carries
// one destination pixel; the result is the linear source index and an inside-frame flag.
// The unit takes one transaction per clock while no stall at the output holds it back. The
// seven register stages are centering, the four angle multipliers, the two sums, the
// Q1.14 scaling, the source offset, the frame test with the row multiplier, and the index
// add. Each stage holds its own valid bit, so a stall at the output fills empty stages
// before input is held. Depends on rimau_pkg and the three stage modules.
module rotate_inverse_map_address_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rimau_pkg::CADDR_W-1:0] i_cfg_addr,
    input  logic [rimau_pkg::ANGLE_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rimau_pkg::COORD_W-1:0] i_dst_col,
    input  logic [rimau_pkg::COORD_W-1:0] i_dst_row,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rimau_pkg::INDEX_W-1:0] o_src_index,
    output logic                          o_in_image
);
    import rimau_pkg::*;

    t_cfg                  r_cfg;
    logic [N_STAGES-1:0]   r_vld;
    logic [N_STAGES-1:0]   n_en;
    logic signed [CTR_W-1:0] w_xc;
    logic signed [CTR_W-1:0] w_yc;
    logic signed [ROT_W-1:0] w_xs;
    logic signed [ROT_W-1:0] w_ys;

    always_comb begin
        n_en[N_STAGES-1] = !r_vld[N_STAGES-1] || i_out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_cfg.cos_v <= ANGLE_W'(16384);
            r_cfg.sin_v <= '0;
            r_cfg.src_w <= DIM_W'(1024);
            r_cfg.src_h <= DIM_W'(1024);
            r_cfg.dst_w <= DIM_W'(1024);
            r_cfg.dst_h <= DIM_W'(1024);
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_COS:   r_cfg.cos_v <= i_cfg_wdata;
                    REG_SIN:   r_cfg.sin_v <= i_cfg_wdata;
                    REG_SRC_W: r_cfg.src_w <= sat_dim(i_cfg_wdata[DIM_W-1:0]);
                    REG_SRC_H: r_cfg.src_h <= sat_dim(i_cfg_wdata[DIM_W-1:0]);
                    REG_DST_W: r_cfg.dst_w <= sat_dim(i_cfg_wdata[DIM_W-1:0]);
                    REG_DST_H: r_cfg.dst_h <= sat_dim(i_cfg_wdata[DIM_W-1:0]);
                    default: begin
                    end
                endcase
            end
        end
    end

    rimau_center u_center (
        .i_clk     (i_clk),
        .i_en      (n_en[0]),
        .i_cfg     (r_cfg),
        .i_dst_col (i_dst_col),
        .i_dst_row (i_dst_row),
        .o_xc      (w_xc),
        .o_yc      (w_yc)
    );

    rimau_rotate u_rotate (
        .i_clk (i_clk),
        .i_en  (n_en[3:1]),
        .i_cfg (r_cfg),
        .i_xc  (w_xc),
        .i_yc  (w_yc),
        .o_xs  (w_xs),
        .o_ys  (w_ys)
    );

    rimau_locate u_locate (
        .i_clk       (i_clk),
        .i_en        (n_en[6:4]),
        .i_cfg       (r_cfg),
        .i_xs        (w_xs),
        .i_ys        (w_ys),
        .o_src_index (o_src_index),
        .o_in_image  (o_in_image)
    );

    assign o_in_ready  = n_en[0];
    assign o_out_valid = r_vld[N_STAGES-1];

endmodule

>>> sv/rimau_checker.sv
// Port-level checker for the rotation address unit, bound to the top level.
// Depends on rimau_pkg and the assertion macro header.
`include "rotate_inverse_map_address_unit_defines.svh"

module rimau_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [rimau_pkg::CADDR_W-1:0] i_cfg_addr,
    input logic [rimau_pkg::ANGLE_W-1:0] i_cfg_wdata,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [rimau_pkg::COORD_W-1:0] i_dst_col,
    input logic [rimau_pkg::COORD_W-1:0] i_dst_row,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [rimau_pkg::INDEX_W-1:0] o_src_index,
    input logic                          o_in_image
);

    `RIMAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_src_index) && $stable(o_in_image))
    `RIMAU_ASSERT_SAME(a_black_zero, i_clk, i_rst_n, o_out_valid && !o_in_image, o_src_index == '0)
    `RIMAU_ASSERT_SAME(a_ready_only_full, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)
    `RIMAU_ASSERT_SAME(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid)

endmodule

bind rotate_inverse_map_address_unit rimau_checker u_rimau_checker (.*);
